/* hdl/sesf_pkg.sv */
// Shared constants and types for the scanline span filler.
package sesf_pkg;
	localparam int CoordBits = 24;
	localparam int MaxEdges = 1024;
	localparam int MaxCross = 64;
	localparam int MaxSpans = 63;
	localparam int EdgeIdxBits = $clog2(MaxEdges);
	localparam int CrossIdxBits = $clog2(MaxCross);
	localparam int HeldBits = 11;
	localparam int DivBits = 2 * CoordBits + 2;

	typedef logic signed [CoordBits-1:0] coord_t;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_SCAN  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_STORED  = 3'd0,
		ST_HORIZ   = 3'd1,
		ST_FULL    = 3'd2,
		ST_SPAN    = 3'd3,
		ST_NO_SPAN = 3'd4
	} status_t;

	localparam coord_t CoordMax = coord_t'({1'b0, {(CoordBits-1){1'b1}}});
	localparam coord_t CoordMin = coord_t'({1'b1, {(CoordBits-1){1'b0}}});
	localparam int OneRow = 256;
endpackage

/* hdl/scanline_edge_span_filler_top.sv */
// Top level of the scanline span filler: edge store, crossing sort and span emit.
//
//  channel   direction  handshake         payload
//  in        input      in_valid/ready    op, edge_xa..edge_yb, band_top
//  out       output     out_valid/ready   status, span_*, edges_held, bounds, last
//  cfg       input      cfg_we            cfg_wdata (fill rule)
//
// A clear makes no result; a load registers its result and waits until it is taken.
// A scan visits each stored edge in three steps (address, registered read, test),
// runs each crossing through the shared divider, then does an exchange sort of
// n crossings with a read and a compare per pair plus a registered second write
// per swap, then walks the spans in two steps each (S_EMIT, S_EMIT2). The shared
// divider and the single sort comparator set the rate of a scan.
// No clearing pass after reset. The block takes no item until the last result
// of the current item has been accepted; a stalled output simply holds.
module scanline_edge_span_filler_top import sesf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           op,
	input  logic signed [23:0]   edge_xa,
	input  logic signed [23:0]   edge_ya,
	input  logic signed [23:0]   edge_xb,
	input  logic signed [23:0]   edge_yb,
	input  logic signed [23:0]   band_top,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic signed [23:0]   span_left,
	output logic signed [23:0]   span_right,
	output logic signed [23:0]   span_top,
	output logic signed [23:0]   span_bottom,
	output logic [10:0]          edges_held,
	output logic signed [23:0]   lowest_y,
	output logic signed [23:0]   highest_y,
	output logic                 last,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata
);
	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_RDW, S_TEST, S_DIV, S_SORT_RD, S_SORT_CMP,
		S_EMIT, S_EMIT2, S_OUT
	} state_t;

	typedef struct packed {
		coord_t ux;
		coord_t uy;
		coord_t lx;
		coord_t ly;
		logic   dir;
	} edge_t;

	edge_t                   edge_mem [MaxEdges];
	edge_t                   erd_q;
	logic [CoordBits:0]      cx_mem [MaxCross];
	logic                    cd_mem [MaxCross];

	state_t                  state_q;
	logic                    rule_q;
	logic [HeldBits-1:0]     total_q;
	coord_t                  top_q, bot_q;
	coord_t                  btop_q, bbot_q;
	logic [EdgeIdxBits:0]    e_q;
	logic [CrossIdxBits:0]   n_q;
	logic [CrossIdxBits:0]   i_q, j_q;
	logic [CrossIdxBits:0]   k_q;
	logic signed [CoordBits+1:0] wind_q;
	logic signed [CoordBits:0]   xi_q, xj_q;
	logic                    di_q, dj_q;
	logic                    neg_q;
	logic                    pend_q;
	coord_t                  pl_q, pr_q;
	logic                    div_start;
	logic                    div_done;
	logic [DivBits-1:0]      div_num, div_den, div_quo;

	// Second write of a swap is a registered write in the cycle after the compare.
	logic                  sw_q;
	logic [CrossIdxBits:0] swj_q;
	logic signed [CoordBits:0] swx_q;
	logic                  swd_q;

	logic signed [CoordBits+1:0] mid2;
	logic signed [CoordBits+1:0] y0x2, y1x2;
	logic signed [CoordBits:0]   dx;
	logic [CoordBits:0]          adx, dy;
	logic signed [CoordBits+1:0] bot_full;

	assign mid2 = (CoordBits+2)'(btop_q) + (CoordBits+2)'(bbot_q);
	assign y0x2 = (CoordBits+2)'(erd_q.uy) <<< 1;
	assign y1x2 = (CoordBits+2)'(erd_q.ly) <<< 1;
	assign dx = (CoordBits+1)'(erd_q.lx) - (CoordBits+1)'(erd_q.ux);
	assign adx = dx[CoordBits] ? (CoordBits+1)'(-dx) : dx;
	assign dy = (CoordBits+1)'((CoordBits+1)'(erd_q.ly) - (CoordBits+1)'(erd_q.uy));
	// Rounded offset: floor((a*|dx| + dy) / (2*dy)), a = mid2 - 2*y0.
	assign div_num = DivBits'(unsigned'(mid2 - y0x2)) * DivBits'(adx) + DivBits'(dy);
	assign div_den = DivBits'({dy, 1'b0});
	assign div_start = (state_q == S_TEST) && (y0x2 <= mid2) && (mid2 < y1x2)
		&& (n_q < (CrossIdxBits+1)'(MaxCross));

	sesf_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .done(div_done), .quotient(div_quo)
	);

	logic signed [CoordBits+1:0] wind_nx;
	assign wind_nx = wind_q + (di_q ? (CoordBits+2)'(1) : -(CoordBits+2)'(1));
	assign bot_full = (CoordBits+2)'(band_top) + (CoordBits+2)'(OneRow);

	assign in_ready = (state_q == S_IDLE);
	assign edges_held = total_q;
	assign lowest_y = top_q;
	assign highest_y = bot_q;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && op == OP_LOAD && total_q < HeldBits'(MaxEdges)
				&& edge_ya != edge_yb) begin
			edge_mem[total_q[EdgeIdxBits-1:0]] <= (edge_ya < edge_yb)
				? edge_t'{edge_xa, edge_ya, edge_xb, edge_yb, 1'b1}
				: edge_t'{edge_xb, edge_yb, edge_xa, edge_ya, 1'b0};
		end
		// The edge under test stays put while its division runs.
		if (state_q == S_RD) erd_q <= edge_mem[e_q[EdgeIdxBits-1:0]];
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			cx_mem[n_q[CrossIdxBits-1:0]] <= neg_q
				? (CoordBits+1)'(erd_q.ux) - (CoordBits+1)'(div_quo)
				: (CoordBits+1)'(erd_q.ux) + (CoordBits+1)'(div_quo);
			cd_mem[n_q[CrossIdxBits-1:0]] <= erd_q.dir;
		end else if (state_q == S_SORT_CMP && xi_q > xj_q) begin
			cx_mem[i_q[CrossIdxBits-1:0]] <= xj_q;
			cd_mem[i_q[CrossIdxBits-1:0]] <= dj_q;
		end else if (sw_q) begin
			cx_mem[swj_q[CrossIdxBits-1:0]] <= swx_q;
			cd_mem[swj_q[CrossIdxBits-1:0]] <= swd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rule_q  <= 1'b0;
			total_q <= '0;
			top_q   <= CoordMax;
			bot_q   <= CoordMin;
			out_valid <= 1'b0;
			sw_q    <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			if (cfg_we) rule_q <= cfg_wdata;
			sw_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (op)
							OP_CLEAR: begin
								total_q <= '0;
								top_q <= CoordMax;
								bot_q <= CoordMin;
							end
							OP_LOAD: begin
								status <= ST_STORED;
								span_left <= '0; span_right <= '0;
								span_top <= '0; span_bottom <= '0;
								last <= 1'b1;
								if (total_q >= HeldBits'(MaxEdges)) status <= ST_FULL;
								else if (edge_ya == edge_yb) status <= ST_HORIZ;
								else begin
									total_q <= total_q + 1'b1;
									if ((edge_ya < edge_yb ? edge_ya : edge_yb) < top_q)
										top_q <= edge_ya < edge_yb ? edge_ya : edge_yb;
									if ((edge_ya < edge_yb ? edge_yb : edge_ya) > bot_q)
										bot_q <= edge_ya < edge_yb ? edge_yb : edge_ya;
								end
								out_valid <= 1'b1;
								state_q <= S_OUT;
							end
							OP_SCAN: begin
								btop_q <= band_top;
								if (bot_full > (CoordBits+2)'(bot_q)) bbot_q <= bot_q;
								else if (bot_full > (CoordBits+2)'(CoordMax)) bbot_q <= CoordMax;
								else bbot_q <= coord_t'(bot_full);
								e_q <= '0; n_q <= '0; k_q <= '0; wind_q <= '0;
								i_q <= '0; pend_q <= 1'b0;
								if (total_q != '0 && band_top < bot_q) state_q <= S_RD;
								else state_q <= S_EMIT;
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					if (e_q >= (EdgeIdxBits+1)'(total_q) || n_q >= (CrossIdxBits+1)'(MaxCross)) begin
						i_q <= '0; j_q <= (CrossIdxBits+1)'(1);
						state_q <= S_SORT_RD;
					end else state_q <= S_RDW;
				end
				S_RDW: state_q <= S_TEST;
				S_TEST: begin
					neg_q <= dx[CoordBits];
					e_q <= e_q + 1'b1;
					state_q <= div_start ? S_DIV : S_RD;
				end
				S_DIV: begin
					if (div_done) begin
						n_q <= n_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_SORT_RD: begin
					if (sw_q) begin
						state_q <= S_SORT_RD;
					end else if (j_q >= n_q) begin
						i_q <= '0;
						state_q <= S_EMIT;
					end else begin
						xi_q <= cx_mem[i_q[CrossIdxBits-1:0]];
						di_q <= cd_mem[i_q[CrossIdxBits-1:0]];
						xj_q <= cx_mem[j_q[CrossIdxBits-1:0]];
						dj_q <= cd_mem[j_q[CrossIdxBits-1:0]];
						state_q <= S_SORT_CMP;
					end
				end
				S_SORT_CMP: begin
					if (xi_q > xj_q) begin
						sw_q <= 1'b1; swj_q <= j_q; swx_q <= xi_q; swd_q <= di_q;
					end
					if (j_q + 1'b1 >= n_q) begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + (CrossIdxBits+1)'(2);
					end else j_q <= j_q + 1'b1;
					state_q <= S_SORT_RD;
				end
				// One span is held back so that the final one goes out marked last.
				S_EMIT: begin
					if (!out_valid || out_ready) begin
						if (i_q + 1'b1 >= n_q || k_q >= (CrossIdxBits+1)'(MaxSpans)) begin
							status <= pend_q ? ST_SPAN : ST_NO_SPAN;
							span_left <= pend_q ? pl_q : '0;
							span_right <= pend_q ? pr_q : '0;
							span_top <= btop_q; span_bottom <= bbot_q;
							last <= 1'b1; out_valid <= 1'b1;
							state_q <= S_OUT;
						end else begin
							out_valid <= 1'b0;
							xi_q <= cx_mem[i_q[CrossIdxBits-1:0]];
							di_q <= cd_mem[i_q[CrossIdxBits-1:0]];
							xj_q <= cx_mem[CrossIdxBits'(i_q + 1'b1)];
							state_q <= S_EMIT2;
						end
					end
				end
				S_EMIT2: begin
					if (rule_q) begin
						i_q <= i_q + (CrossIdxBits+1)'(2);
					end else begin
						i_q <= i_q + 1'b1;
						wind_q <= wind_nx;
					end
					if (rule_q || wind_nx != '0) begin
						if (pend_q) begin
							status <= ST_SPAN;
							span_left <= pl_q; span_right <= pr_q;
							span_top <= btop_q; span_bottom <= bbot_q;
							last <= 1'b0; out_valid <= 1'b1;
						end
						pend_q <= 1'b1;
						pl_q <= coord_t'(xi_q); pr_q <= coord_t'(xj_q);
						k_q <= k_q + 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_OUT: begin
					if (out_valid && out_ready) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hdl/sesf_divider.sv */
// Restoring divider that produces one quotient bit per cycle.
module sesf_divider import sesf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DivBits-1:0]  dividend,
	input  logic [DivBits-1:0]  divisor,
	output logic                done,
	output logic [DivBits-1:0]  quotient
);
	localparam int CntBits = $clog2(DivBits + 1);

	logic [DivBits-1:0] rem_q;
	logic [DivBits-1:0] quo_q;
	logic [DivBits-1:0] den_q;
	logic [CntBits-1:0] cnt_q;
	logic               busy_q;
	logic [DivBits:0]   trial;

	assign trial = {rem_q, quo_q[DivBits-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntBits'(DivBits);
				rem_q  <= '0;
				quo_q  <= dividend;
				den_q  <= divisor;
			end else if (busy_q) begin
				if (!trial[DivBits]) begin
					rem_q <= trial[DivBits-1:0];
					quo_q <= {quo_q[DivBits-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DivBits-2:0], quo_q[DivBits-1]};
					quo_q <= {quo_q[DivBits-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntBits'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quotient = quo_q;
endmodule

/* hdl/sesf_checker.sv */
// Port-level checks for the scanline span filler, bound to the top level.
module sesf_checker import sesf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [10:0] edges_held,
	input logic        last
);
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped under stall");
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		edges_held <= 11'(MaxEdges)) else $error("edge count too large");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_STORED || status == ST_HORIZ || status == ST_FULL
		|| status == ST_NO_SPAN) |-> last) else $error("single result not last");
endmodule

bind scanline_edge_span_filler_top sesf_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.edges_held(edges_held), .last(last)
);

/* bench/scanline_edge_span_filler_top_test.sv */
// Self-checking testbench for the scanline span filler: edge loads, band scans and fill rules.
module scanline_edge_span_filler_top_test import sesf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RunLimit = 1500000;
	localparam int DrainCycles = 200;
	localparam int FillEdges = 65;

	typedef struct {
		logic [1:0]  op;
		logic [23:0] xa, ya, xb, yb, bt;
	} edge_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [23:0] left, right, top, bottom;
		logic [10:0] held;
		logic [23:0] lo, hi;
		logic        last;
	} span_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready;
	logic [1:0] op = OP_CLEAR;
	logic signed [23:0] edge_xa = '0, edge_ya = '0, edge_xb = '0, edge_yb = '0, band_top = '0;
	logic out_valid, out_ready = 1'b0;
	logic [2:0] status;
	logic signed [23:0] span_left, span_right, span_top, span_bottom, lowest_y, highest_y;
	logic [10:0] edges_held;
	logic last;
	logic cfg_we = 1'b0, cfg_wdata = 1'b0;

	scanline_edge_span_filler_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.edge_xa(edge_xa), .edge_ya(edge_ya), .edge_xb(edge_xb), .edge_yb(edge_yb),
		.band_top(band_top),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.span_left(span_left), .span_right(span_right),
		.span_top(span_top), .span_bottom(span_bottom),
		.edges_held(edges_held), .lowest_y(lowest_y), .highest_y(highest_y), .last(last),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	edge_cmd_t    pending_cmds[$];
	span_result_t expected_spans[$];
	int mismatches = 0;
	int cycle_count = 0;
	logic rule_even_odd = 1'b0;
	logic calm = 1'b0;

	// Shadow of the block's edge store and bounds.
	longint store_ux[MaxEdges], store_uy[MaxEdges], store_lx[MaxEdges], store_ly[MaxEdges];
	bit     store_down[MaxEdges];
	int     store_count = 0;
	longint bound_top = longint'(CoordMax);
	longint bound_bottom = longint'(CoordMin);

	function automatic longint sx(logic [23:0] v);
		return longint'($signed(v));
	endfunction

	function automatic span_result_t make_result(logic [2:0] st, longint l, longint r,
			longint t, longint b, logic lst);
		span_result_t res;
		res.status = st;
		res.left = l[23:0];
		res.right = r[23:0];
		res.top = t[23:0];
		res.bottom = b[23:0];
		res.held = store_count[10:0];
		res.lo = bound_top[23:0];
		res.hi = bound_bottom[23:0];
		res.last = lst;
		return res;
	endfunction

	function automatic void predict_spans(edge_cmd_t c);
		longint xa, ya, xb, yb, top, bot, mid2, dy, dx, adx, mag, tx;
		longint cx[MaxCross];
		int     cd[MaxCross];
		longint sl[MaxSpans], sr[MaxSpans];
		int n, k, wind, td;
		status_t st;
		n = 0;
		k = 0;
		xa = sx(c.xa); ya = sx(c.ya); xb = sx(c.xb); yb = sx(c.yb);
		if (c.op == OP_CLEAR) begin
			store_count = 0;
			bound_top = longint'(CoordMax);
			bound_bottom = longint'(CoordMin);
		end else if (c.op == OP_LOAD) begin
			if (store_count >= MaxEdges) begin
				st = ST_FULL;
			end else if (ya == yb) begin
				st = ST_HORIZ;
			end else begin
				store_down[store_count] = ya < yb;
				store_ux[store_count] = (ya < yb) ? xa : xb;
				store_uy[store_count] = (ya < yb) ? ya : yb;
				store_lx[store_count] = (ya < yb) ? xb : xa;
				store_ly[store_count] = (ya < yb) ? yb : ya;
				if (store_uy[store_count] < bound_top) bound_top = store_uy[store_count];
				if (store_ly[store_count] > bound_bottom) bound_bottom = store_ly[store_count];
				store_count++;
				st = ST_STORED;
			end
			expected_spans.push_back(make_result(st, 0, 0, 0, 0, 1'b1));
		end else if (c.op == OP_SCAN) begin
			top = sx(c.bt);
			bot = top + OneRow;
			if (bot > longint'(CoordMax)) bot = longint'(CoordMax);
			if (bot > bound_bottom) bot = bound_bottom;
			if (store_count > 0 && top < bound_bottom) begin
				mid2 = top + bot;
				for (int e = 0; e < store_count && n < MaxCross; e++) begin
					if (2 * store_uy[e] <= mid2 && mid2 < 2 * store_ly[e]) begin
						dy = store_ly[e] - store_uy[e];
						dx = store_lx[e] - store_ux[e];
						adx = dx < 0 ? -dx : dx;
						// Exact quotient rounded half away from zero.
						mag = ((mid2 - 2 * store_uy[e]) * adx + dy) / (2 * dy);
						cx[n] = dx < 0 ? store_ux[e] - mag : store_ux[e] + mag;
						cd[n] = store_down[e] ? 1 : -1;
						n++;
					end
				end
			end
			for (int i = 0; i + 1 < n; i++)
				for (int j = i + 1; j < n; j++)
					if (cx[i] > cx[j]) begin
						tx = cx[i]; cx[i] = cx[j]; cx[j] = tx;
						td = cd[i]; cd[i] = cd[j]; cd[j] = td;
					end
			if (rule_even_odd) begin
				for (int i = 0; i + 1 < n && k < MaxSpans; i += 2) begin
					sl[k] = cx[i]; sr[k] = cx[i + 1]; k++;
				end
			end else begin
				wind = 0;
				for (int i = 0; i + 1 < n && k < MaxSpans; i++) begin
					wind += cd[i];
					if (wind != 0) begin
						sl[k] = cx[i]; sr[k] = cx[i + 1]; k++;
					end
				end
			end
			if (k == 0)
				expected_spans.push_back(make_result(ST_NO_SPAN, 0, 0, top, bot, 1'b1));
			for (int j = 0; j < k; j++)
				expected_spans.push_back(make_result(ST_SPAN, sl[j], sr[j], top, bot, j == k - 1));
		end
	endfunction

	// Sender: bursts of items separated by random gaps.
	edge_cmd_t shown;
	int burst_left = 0, gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) predict_spans(shown);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					shown = pending_cmds.pop_front();
					op <= shown.op;
					edge_xa <= shown.xa; edge_ya <= shown.ya;
					edge_xb <= shown.xb; edge_yb <= shown.yb;
					band_top <= shown.bt;
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left = calm ? 0 : $urandom_range(0, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stalls in short runs; calm stretches turn stalls and gaps off.
	int stall_left = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count % 300 == 0) calm = $urandom_range(0, 2) == 0;
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 8);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
		if (cycle_count > RunLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	span_result_t got, want;
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got.status = status; got.left = span_left; got.right = span_right;
			got.top = span_top; got.bottom = span_bottom; got.held = edges_held;
			got.lo = lowest_y; got.hi = highest_y; got.last = last;
			if (expected_spans.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result: %p", got);
			end else begin
				want = expected_spans.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	task automatic push_cmd(logic [1:0] o, int xa, int ya, int xb, int yb, int bt);
		edge_cmd_t c;
		c.op = o; c.xa = xa[23:0]; c.ya = ya[23:0]; c.xb = xb[23:0]; c.yb = yb[23:0];
		c.bt = bt[23:0];
		pending_cmds.push_back(c);
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_cmds.size() != 0 || in_valid || expected_spans.size() != 0);
		// A trailing clear makes no result, so let it finish.
		repeat (20) @(posedge clk);
	endtask

	task automatic set_rule(logic v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		rule_even_odd = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic fill_store(bit all_down, int n_edges);
		int ya, yb;
		push_cmd(OP_CLEAR, 0, 0, 0, 0, 0);
		for (int i = 0; i < n_edges; i++) begin
			ya = -$urandom_range(1, 2560);
			yb = $urandom_range(1, 2560);
			if (all_down || $urandom_range(0, 1))
				push_cmd(OP_LOAD, $urandom_range(0, 8000) - 4000, ya,
					$urandom_range(0, 8000) - 4000, yb, 0);
			else
				push_cmd(OP_LOAD, $urandom_range(0, 8000) - 4000, yb,
					$urandom_range(0, 8000) - 4000, ya, 0);
		end
		push_cmd(OP_LOAD, 1, 2, 3, 4, 0);
		push_cmd(OP_LOAD, 5, 7, 5, 7, 0);
		push_cmd(OP_SCAN, 0, 0, 0, 0, -128);
	endtask

	task automatic random_polygon();
		int nv, x0, y0, px, py, qx, qy;
		push_cmd(OP_CLEAR, 0, 0, 0, 0, 0);
		nv = $urandom_range(3, 10);
		x0 = $urandom_range(0, 6000) - 3000; y0 = $urandom_range(0, 6000) - 3000;
		px = x0; py = y0;
		for (int i = 1; i <= nv; i++) begin
			if (i == nv) begin
				qx = x0; qy = y0;
			end else begin
				qx = $urandom_range(0, 6000) - 3000;
				qy = $urandom_range(0, 8) == 0 ? py : $urandom_range(0, 6000) - 3000;
			end
			push_cmd(OP_LOAD, px, py, qx, qy, 0);
			px = qx; py = qy;
		end
		repeat ($urandom_range(2, 5))
			push_cmd(OP_SCAN, 0, 0, 0, 0, $urandom_range(0, 6600) - 3300);
	endtask

	task automatic random_noise();
		push_cmd(2'($urandom_range(0, 3)), int'($urandom), int'($urandom), int'($urandom),
			int'($urandom), int'($urandom));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: empty scan, extremes, horizontal edge, ignored op, saturation.
		push_cmd(OP_SCAN, 0, 0, 0, 0, 0);
		push_cmd(OP_LOAD, 100, 50, 900, 50, 0);
		push_cmd(OP_LOAD, int'(CoordMin), int'(CoordMin), int'(CoordMax), int'(CoordMax), 0);
		push_cmd(OP_LOAD, int'(CoordMax), int'(CoordMax), int'(CoordMin), int'(CoordMin), 0);
		push_cmd(OP_SCAN, 0, 0, 0, 0, int'(CoordMax));
		push_cmd(OP_SCAN, 0, 0, 0, 0, int'(CoordMin));
		push_cmd(OP_SCAN, 0, 0, 0, 0, int'(CoordMax) - 100);
		push_cmd(2'd3, -1, -1, -1, -1, -1);
		push_cmd(OP_CLEAR, 0, 0, 0, 0, 0);
		// Square with a nested square of the same winding, then band scans.
		push_cmd(OP_LOAD, 0, 0, 0, 2560, 0);
		push_cmd(OP_LOAD, 2560, 2560, 2560, 0, 0);
		push_cmd(OP_LOAD, 512, 512, 512, 1024, 0);
		push_cmd(OP_LOAD, 1024, 1024, 1024, 512, 0);
		push_cmd(OP_LOAD, 0, 0, 2560, 0, 0);
		push_cmd(OP_SCAN, 0, 0, 0, 0, 700);
		push_cmd(OP_SCAN, 0, 0, 0, 0, 2500);
		push_cmd(OP_SCAN, 0, 0, 0, 0, 2560);
		push_cmd(OP_SCAN, 0, 0, 0, 0, -300);
		push_cmd(OP_LOAD, 300, 0, -77, 1333, 0);
		push_cmd(OP_SCAN, 0, 0, 0, 0, 100);
		set_rule(1'b1);
		push_cmd(OP_SCAN, 0, 0, 0, 0, 700);
		push_cmd(OP_SCAN, 0, 0, 0, 0, 100);
		// Crowded store: overflow of crossings and of spans.
		set_rule(1'b0);
		fill_store(1'b1, FillEdges);
		set_rule(1'b1);
		push_cmd(OP_SCAN, 0, 0, 0, 0, -128);
		for (int ph = 0; ph < 2; ph++) begin
			set_rule(ph[0]);
			random_polygon();
			repeat ($urandom_range(0, 2)) random_noise();
		end
		wait_idle();
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0 && expected_spans.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

/* scanline_edge_span_filler_top.f */
hdl/sesf_pkg.sv
hdl/sesf_divider.sv
hdl/scanline_edge_span_filler_top.sv
hdl/sesf_checker.sv
bench/scanline_edge_span_filler_top_test.sv
